// ----- src/fnv1a_fmix64_hash_unit_macros.svh -----
// assertion macros for the fnv1a/fmix64 hash unit
// used by the top level only, no other dependencies
`ifndef FNV1A_FMIX64_HASH_UNIT_MACROS_SVH
`define FNV1A_FMIX64_HASH_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked while out of reset
`define FNVFM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define FNVFM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FNVFM_ASSERT(lbl, prop, msg)
`define FNVFM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- src/fnvfm_pkg.sv -----
// shared constants and types of the fnv1a/fmix64 hash unit
// no dependencies
`timescale 1ns / 1ps
package fnvfm_pkg;
    localparam int HASH_W = 64;
    localparam int HALF_W = 32;
    localparam logic [HASH_W-1:0] FNV_OFFSET_BASIS = 64'hcbf29ce484222325;
    localparam logic [HASH_W-1:0] FMIX_MUL_A = 64'hff51afd7ed558ccd;
    localparam logic [HASH_W-1:0] FMIX_MUL_B = 64'hc4ceb9fe1a85ec53;
    localparam int FMIX_SHIFT = 33;

    // head of the hand-off queue as seen by the finalizer
    typedef struct packed {
        logic              valid;
        logic [HASH_W-1:0] data;
    } q_head_t;

    // queue fill status for the front side
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MA0,
        B_MA1,
        B_MA2,
        B_MB0,
        B_MB1,
        B_MB2,
        B_DONE
    } back_state_t;
endpackage

// ----- src/fnv1a_fmix64_hash_unit.sv -----
// top level of the fnv1a/fmix64 hash unit: front, hand-off queue, finalizer
// depends on fnvfm_pkg, fnvfm_front, fnvfm_queue, fnvfm_back and the macros header
//
// usage
//   input channel: one word per string byte (data_byte, has_byte, last) under
//   in_valid / in_stall. has_byte clear with last set hashes an empty string;
//   has_byte and last both clear is a no-op word
//   output channel: one hash_value word per string, under out_valid / out_stall
// throughput
//   bytes are absorbed at one word per cycle while in_stall is low; the fnv prime
//   multiply is shift-add logic in the front. per string the finalizer pops, forms
//   six 32x32 partial products on one shared multiplier and fills the output register,
//   so strings of fewer bytes than these steps are limited by the finalizer
// stalls
//   a held result stalls the finalizer; finished strings then wait in the
//   hand-off queue (QUEUE_DEPTH entries), and in_stall rises only once it fills.
//   bytes of the next string keep flowing until then
// reset
//   asynchronous, active low: running hash back to the fnv offset basis,
//   queue empty, no result pending
`timescale 1ns / 1ps
`include "fnv1a_fmix64_hash_unit_macros.svh"
module fnv1a_fmix64_hash_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   data_byte,
    input  logic                         has_byte,
    input  logic                         last,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [fnvfm_pkg::HASH_W-1:0] hash_value
);
    import fnvfm_pkg::*;

    logic              in_accept;
    logic              push;
    logic [HASH_W-1:0] push_data;
    logic              pop;
    q_head_t           head;
    q_stat_t           stat;

    // stall whenever the queue is full, so a last word always finds room
    assign in_stall  = stat.full;
    assign in_accept = in_valid && !in_stall;

    fnvfm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .data_byte (data_byte),
        .has_byte  (has_byte),
        .last      (last),
        .push      (push),
        .push_data (push_data)
    );

    fnvfm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (stat)
    );

    fnvfm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hash_value (hash_value)
    );

    // finalizer only takes from a non-empty queue
    `FNVFM_ASSERT(a_pop_nonempty, pop |-> !stat.empty, "finalizer popped an empty queue")
    // finalizer never takes new work while a result is on offer
    `FNVFM_ASSERT(a_no_pop_while_out, out_valid |-> !pop, "pop while result pending")
    // a last word accepted into a queue without room would be lost
    `FNVFM_ASSERT(a_push_room, push |-> !stat.full, "push into full queue")
    // nothing on offer from the edge after reset has been seen
    `FNVFM_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid && !in_stall,
        "output or stall active in reset")
endmodule

// ----- src/fnvfm_front.sv -----
// byte absorber: running fnv-1a hash, hands finished strings to the queue
// depends on fnvfm_pkg
`timescale 1ns / 1ps
module fnvfm_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [7:0]                data_byte,
    input  logic                      has_byte,
    input  logic                      last,
    output logic                      push,
    output logic [fnvfm_pkg::HASH_W-1:0] push_data
);
    import fnvfm_pkg::*;

    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_next;
    logic [HASH_W-1:0] mixed;
    logic [HASH_W-1:0] absorbed;

    // prime is 2^40 + 0x1b3, so the multiply is a handful of shifted adds
    always_comb
    begin
        mixed = hash_reg ^ {{(HASH_W-8){1'b0}}, data_byte};
        absorbed = (mixed << 40) + (mixed << 8) + (mixed << 7) + (mixed << 5)
                 + (mixed << 4) + (mixed << 1) + mixed;
    end

    always_comb
    begin
        push_data = has_byte ? absorbed : hash_reg;
        push      = accept && last;
        hash_next = hash_reg;
        if (accept)
        begin
            hash_next = last ? FNV_OFFSET_BASIS : push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= FNV_OFFSET_BASIS;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end
endmodule

// ----- src/fnvfm_queue.sv -----
// short hand-off queue of absorbed hashes between front and finalizer
// depends on fnvfm_pkg
`timescale 1ns / 1ps
module fnvfm_queue #(
    parameter int DEPTH = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [fnvfm_pkg::HASH_W-1:0] push_data,
    input  logic                         pop,
    output fnvfm_pkg::q_head_t           head,
    output fnvfm_pkg::q_stat_t           stat
);
    import fnvfm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [HASH_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    always_comb
    begin
        stat.full   = (count_reg == FULL_CNT);
        stat.empty  = (count_reg == '0);
        head.valid  = !stat.empty;
        head.data   = entry_reg[rd_ptr_reg];
        do_push     = push && !stat.full;
        do_pop      = pop && !stat.empty;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule

// ----- src/fnvfm_back.sv -----
// murmur3 fmix64 finalizer on one shared 32x32 multiplier, plus output register
// depends on fnvfm_pkg
`timescale 1ns / 1ps
module fnvfm_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fnvfm_pkg::q_head_t           head,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [fnvfm_pkg::HASH_W-1:0] hash_value
);
    import fnvfm_pkg::*;

    back_state_t       state_reg, state_next;
    logic [HASH_W-1:0] x_reg, x_next;
    logic [HASH_W-1:0] acc_reg, acc_next;
    logic [HASH_W-1:0] res_reg, res_next;
    logic [HALF_W-1:0] op_a;
    logic [HALF_W-1:0] op_b;
    logic [HASH_W-1:0] prod;
    logic [HASH_W-1:0] acc_sum;
    logic [HASH_W-1:0] mixed_sum;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: if (head.valid) state_next = B_MA0;
            B_MA0:  state_next = B_MA1;
            B_MA1:  state_next = B_MA2;
            B_MA2:  state_next = B_MB0;
            B_MB0:  state_next = B_MB1;
            B_MB1:  state_next = B_MB2;
            B_MB2:  state_next = B_DONE;
            B_DONE: if (!out_stall) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // low 64 bits of x*c: xl*cl + ((xh*cl + xl*ch) << 32), one product a cycle
    always_comb
    begin
        op_a = x_reg[HALF_W-1:0];
        op_b = FMIX_MUL_A[HALF_W-1:0];
        case (state_reg)
            B_MA1:   op_a = x_reg[HASH_W-1:HALF_W];
            B_MA2:   op_b = FMIX_MUL_A[HASH_W-1:HALF_W];
            B_MB0:   op_b = FMIX_MUL_B[HALF_W-1:0];
            B_MB1:
            begin
                op_a = x_reg[HASH_W-1:HALF_W];
                op_b = FMIX_MUL_B[HALF_W-1:0];
            end
            B_MB2:   op_b = FMIX_MUL_B[HASH_W-1:HALF_W];
            default: op_b = FMIX_MUL_A[HALF_W-1:0];
        endcase
        prod      = HASH_W'(op_a) * HASH_W'(op_b);
        acc_sum   = acc_reg + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
        mixed_sum = acc_sum ^ (acc_sum >> FMIX_SHIFT);
    end

    always_comb
    begin
        pop       = 1'b0;
        out_valid = (state_reg == B_DONE);
        x_next    = x_reg;
        acc_next  = acc_reg;
        res_next  = res_reg;
        case (state_reg)
            B_IDLE:
            begin
                pop    = head.valid;
                x_next = head.data ^ (head.data >> FMIX_SHIFT);
            end
            B_MA0, B_MB0:  acc_next = prod;
            B_MA1, B_MB1:  acc_next = acc_sum;
            B_MA2:         x_next   = mixed_sum;
            B_MB2:         res_next = mixed_sum;
            default:       acc_next = acc_reg;
        endcase
    end

    assign hash_value = res_reg;

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule
